>>> design/mcpd_pkg.sv
// Shared types, field layout and result codes of the multi-class priority deque.
package mcpd_pkg;

    // Control sequence: latch command, read queue record, deliver result.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_META,
        ST_RESP
    } state_t;

    // Command codes
    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_SERVE = 1'b1;

    // Result codes
    localparam int RC_W = 3;
    localparam logic [RC_W-1:0] RC_ADDED     = 3'd0;
    localparam logic [RC_W-1:0] RC_FULL      = 3'd1;
    localparam logic [RC_W-1:0] RC_SERVED    = 3'd2;
    localparam logic [RC_W-1:0] RC_EMPTY     = 3'd3;
    localparam logic [RC_W-1:0] RC_BAD_INDEX = 3'd4;

    // Field widths on the stream ports
    localparam int CMD_W    = 1;
    localparam int QIDX_W   = 4;
    localparam int ITEM_W   = 16;
    localparam int URGENT_W = 1;
    localparam int COUNT_W  = 4;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_PAD_W   = OUT_TDATA_W - RC_W - ITEM_W - COUNT_W;

    // Wide enough to compare a queue index against a queue count up to 511
    localparam int QCMP_W = 9;

endpackage

>>> design/multi_class_priority_deque.sv
// Top level of the multi-class priority deque: control sequence, pointer math, result stage.
//
// One bounded ring queue of item IDs per class. Commands arrive on the
// s_axis channel, one result per command leaves on the m_axis channel.
// An add (cmd 0) puts item_id at the head when urgent is set, else at the
// tail; a full queue rejects it. A serve (cmd 1) pops the head item or
// reports an empty queue. A queue index of NUM_QUEUES or more is answered
// with the bad-index code and changes nothing.
// Timing: the command is taken in IDLE, the queue record (head, count)
// comes out of the record memory in the next cycle (META), the item
// memory is written or read in META, and the result enters the output
// register from RESP once that register is free. No new command is
// accepted until the last one's result has entered the output register;
// the registered reads of both memories set this sequence.
// The output register parts the two sides: a waiting result does not stop
// the next command from entering; only the result of that next command
// waits in the final step until the receiver takes the old one.
// Reset clears all queue counts and head pointers at once (valid bits on
// the record memory); the item memory is not cleared and needs no pass.
module multi_class_priority_deque #(
    parameter int NUM_QUEUES  = 16,
    parameter int QUEUE_DEPTH = 8,
    parameter int ID_WIDTH    = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Fields from bit 0: cmd, queue_index[3:0], item_id[15:0], urgent, zero pad
    input  logic [mcpd_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // Fields from bit 0: result_code[2:0], served_id[15:0], queue_count[3:0], zero pad
    output logic [mcpd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready
);

    localparam int QW      = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int PW      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW      = $clog2(QUEUE_DEPTH + 1);
    localparam int SW      = CW + 1;
    localparam int MW      = PW + CW;
    localparam int ENTRIES = NUM_QUEUES * QUEUE_DEPTH;
    localparam int EAW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // Input field extraction
    logic                            in_cmd;
    logic [mcpd_pkg::QIDX_W-1:0]     in_qidx;
    logic [mcpd_pkg::ITEM_W-1:0]     in_item;
    logic                            in_urgent;
    logic [QW-1:0]                   in_q;
    logic [ID_WIDTH-1:0]             in_id;
    logic                            in_bad;
    logic                            accept;

    assign in_cmd    = s_axis_tdata[0];
    assign in_qidx   = s_axis_tdata[4:1];
    assign in_item   = s_axis_tdata[20:5];
    assign in_urgent = s_axis_tdata[21];
    assign in_bad    = {{(mcpd_pkg::QCMP_W - mcpd_pkg::QIDX_W){1'b0}}, in_qidx}
                       >= mcpd_pkg::QCMP_W'(NUM_QUEUES);
    assign accept    = s_axis_tvalid && s_axis_tready;

    // Resize queue index and ID bitwise (either side may be the wider one)
    always_comb
    begin
        for (int i = 0; i < QW; i++)
        begin
            in_q[i] = (i < mcpd_pkg::QIDX_W) ? in_qidx[i] : 1'b0;
        end
        for (int i = 0; i < ID_WIDTH; i++)
        begin
            in_id[i] = (i < mcpd_pkg::ITEM_W) ? in_item[i] : 1'b0;
        end
    end

    // Latched command
    logic                cmd_reg;
    logic [QW-1:0]       q_reg;
    logic [ID_WIDTH-1:0] id_reg;
    logic                urgent_reg;
    logic                bad_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= in_cmd;
            q_reg      <= in_q;
            id_reg     <= in_id;
            urgent_reg <= in_urgent;
            bad_reg    <= in_bad;
        end
    end

    // Memories
    logic                meta_rd_en;
    logic [MW-1:0]       meta_rd_data;
    logic                meta_wr_en;
    logic [MW-1:0]       meta_wr_data;
    logic                entry_rd_en;
    logic                entry_wr_en;
    logic [EAW-1:0]      entry_addr;
    logic [ID_WIDTH-1:0] entry_rd_data;

    mcpd_meta_store #(
        .DEPTH (NUM_QUEUES),
        .WIDTH (MW)
    ) u_meta (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (meta_rd_en),
        .rd_addr (in_q),
        .rd_data (meta_rd_data),
        .wr_en   (meta_wr_en),
        .wr_addr (q_reg),
        .wr_data (meta_wr_data)
    );

    mcpd_entry_ram #(
        .DEPTH (ENTRIES),
        .WIDTH (ID_WIDTH)
    ) u_entry (
        .clk     (clk),
        .rd_en   (entry_rd_en),
        .wr_en   (entry_wr_en),
        .addr    (entry_addr),
        .wr_data (id_reg),
        .rd_data (entry_rd_data)
    );

    // Ring pointer math on the fetched record
    logic [PW-1:0]  head_cur;
    logic [CW-1:0]  cnt_cur;
    logic [PW-1:0]  head_dec;
    logic [PW-1:0]  head_inc;
    logic [SW-1:0]  tail_sum;
    logic [PW-1:0]  tail_slot;
    logic           q_full;
    logic           q_empty;
    logic [EAW-1:0] q_base;
    logic [PW-1:0]  slot;

    assign head_cur  = meta_rd_data[PW-1:0];
    assign cnt_cur   = meta_rd_data[MW-1:PW];
    assign head_dec  = (head_cur == '0) ? PW'(QUEUE_DEPTH - 1) : head_cur - 1'b1;
    assign head_inc  = (head_cur == PW'(QUEUE_DEPTH - 1)) ? '0 : head_cur + 1'b1;
    assign tail_sum  = SW'(head_cur) + SW'(cnt_cur);
    // head + count stays below twice the depth: one subtract wraps it
    assign tail_slot = (tail_sum >= SW'(QUEUE_DEPTH)) ? PW'(tail_sum - SW'(QUEUE_DEPTH))
                                                      : PW'(tail_sum);
    assign q_full    = (cnt_cur == CW'(QUEUE_DEPTH));
    assign q_empty   = (cnt_cur == '0);
    assign q_base    = EAW'(q_reg) * EAW'(QUEUE_DEPTH);
    assign entry_addr = q_base + EAW'(slot);

    // Control sequence
    mcpd_pkg::state_t state_reg, state_next;

    logic                       out_valid_reg;
    logic                       out_load;
    logic [mcpd_pkg::RC_W-1:0]  code_reg, code_next;
    logic [CW-1:0]              cnt_reg, cnt_next;

    assign out_load = (state_reg == mcpd_pkg::ST_RESP) && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mcpd_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = mcpd_pkg::ST_META;
                end
            end
            mcpd_pkg::ST_META:
            begin
                state_next = mcpd_pkg::ST_RESP;
            end
            mcpd_pkg::ST_RESP:
            begin
                if (out_load)
                begin
                    state_next = mcpd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mcpd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_axis_tready = 1'b0;
        meta_rd_en    = 1'b0;
        meta_wr_en    = 1'b0;
        meta_wr_data  = {cnt_cur, head_cur};
        entry_rd_en   = 1'b0;
        entry_wr_en   = 1'b0;
        slot          = head_cur;
        code_next     = code_reg;
        cnt_next      = cnt_reg;
        case (state_reg)
            mcpd_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                meta_rd_en    = s_axis_tvalid;
            end
            mcpd_pkg::ST_META:
            begin
                if (bad_reg)
                begin
                    code_next = mcpd_pkg::RC_BAD_INDEX;
                    cnt_next  = '0;
                end
                else if (cmd_reg == mcpd_pkg::CMD_ADD)
                begin
                    if (q_full)
                    begin
                        code_next = mcpd_pkg::RC_FULL;
                        cnt_next  = cnt_cur;
                    end
                    else
                    begin
                        // urgent: new head one slot back; regular: write behind the tail
                        slot         = urgent_reg ? head_dec : tail_slot;
                        entry_wr_en  = 1'b1;
                        meta_wr_en   = 1'b1;
                        meta_wr_data = {cnt_cur + 1'b1, urgent_reg ? head_dec : head_cur};
                        code_next    = mcpd_pkg::RC_ADDED;
                        cnt_next     = cnt_cur + 1'b1;
                    end
                end
                else
                begin
                    if (q_empty)
                    begin
                        code_next = mcpd_pkg::RC_EMPTY;
                        cnt_next  = '0;
                    end
                    else
                    begin
                        slot         = head_cur;
                        entry_rd_en  = 1'b1;
                        meta_wr_en   = 1'b1;
                        meta_wr_data = {cnt_cur - 1'b1, head_inc};
                        code_next    = mcpd_pkg::RC_SERVED;
                        cnt_next     = cnt_cur - 1'b1;
                    end
                end
            end
            mcpd_pkg::ST_RESP:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mcpd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
        cnt_reg  <= cnt_next;
    end

    // Result stage
    logic [mcpd_pkg::ITEM_W-1:0]  served_id;
    logic [mcpd_pkg::COUNT_W-1:0] count_out;
    logic [mcpd_pkg::RC_W-1:0]    out_code_reg;
    logic [mcpd_pkg::ITEM_W-1:0]  out_id_reg;
    logic [mcpd_pkg::COUNT_W-1:0] out_cnt_reg;

    always_comb
    begin
        for (int i = 0; i < mcpd_pkg::ITEM_W; i++)
        begin
            served_id[i] = (i < ID_WIDTH) ? entry_rd_data[i] : 1'b0;
        end
        // count shown modulo 16
        for (int i = 0; i < mcpd_pkg::COUNT_W; i++)
        begin
            count_out[i] = (i < CW) ? cnt_reg[i] : 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_code_reg <= code_reg;
            out_id_reg   <= (code_reg == mcpd_pkg::RC_SERVED) ? served_id : '0;
            out_cnt_reg  <= count_out;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{mcpd_pkg::OUT_PAD_W{1'b0}}, out_cnt_reg, out_id_reg, out_code_reg};

endmodule

>>> design/mcpd_meta_store.sv
// Per-queue record memory (head pointer and count) with reset-cleared valid bits.
module mcpd_meta_store #(
    parameter int  DEPTH = 16,
    parameter int  WIDTH = 7,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     rd_en,
    input  logic [AW-1:0]            rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [AW-1:0]            wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [WIDTH-1:0] rd_data_reg;
    logic             rd_valid_reg;

    // Records never written read as zero (empty queue, head at slot 0).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

>>> design/mcpd_entry_ram.sv
// Single-port item ID memory holding every queue's ring slots.
module mcpd_entry_ram #(
    parameter int  DEPTH = 128,
    parameter int  WIDTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             rd_en,
    input  logic             wr_en,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wr_data,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/mcpd_checker.sv
// Port-level checks of the multi-class priority deque and their bind.
module mcpd_checker #(
    parameter int QUEUE_DEPTH = 8
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [mcpd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready
);

    logic [mcpd_pkg::RC_W-1:0]    rc;
    logic [mcpd_pkg::ITEM_W-1:0]  sid;
    logic [mcpd_pkg::COUNT_W-1:0] cnt;

    assign rc  = m_axis_tdata[2:0];
    assign sid = m_axis_tdata[18:3];
    assign cnt = m_axis_tdata[22:19];

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // one command at a time
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("command accepted while one is in flight");

    a_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && rc != mcpd_pkg::RC_SERVED |-> sid == '0)
        else $error("served_id nonzero on non-serve result");

    a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && rc == mcpd_pkg::RC_FULL |-> cnt == mcpd_pkg::COUNT_W'(QUEUE_DEPTH))
        else $error("full result with wrong count");

    a_zero_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (rc == mcpd_pkg::RC_BAD_INDEX || rc == mcpd_pkg::RC_EMPTY)
        |-> cnt == '0)
        else $error("bad-index or empty result with nonzero count");

endmodule

bind multi_class_priority_deque mcpd_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_mcpd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);
